// ----- rtl/branch_target_buffer_unit_defines.svh -----
// assertion macros used by the branch target buffer top level
`ifndef BRANCH_TARGET_BUFFER_UNIT_DEFINES_SVH
`define BRANCH_TARGET_BUFFER_UNIT_DEFINES_SVH

`ifndef SYNTH

// property must hold at every rising clock edge out of reset
`define BTB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("btb assertion failed");

// condition must never be true out of reset
`define BTB_ASSERT_NEVER(name, cond) \
  `BTB_ASSERT(name, !(cond))

`else

`define BTB_ASSERT(name, prop)
`define BTB_ASSERT_NEVER(name, cond)

`endif

`endif

// ----- rtl/btb_pkg.sv -----
// types and constants of the branch target buffer
`default_nettype none

package btb_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned USES_W      = 16;
  localparam logic [USES_W-1:0] USES_MAX = '1;

  localparam logic       OP_FETCH   = 1'b0;
  localparam logic       OP_UPDATE  = 1'b1;
  localparam logic [1:0] PRED_NOT_SET = 2'd0;
  localparam logic [1:0] PRED_TAKEN   = 2'd2;
  localparam logic [31:0] PC_STEP     = 32'd4;

  // one input beat
  typedef struct packed {
    logic               op;
    logic [31:0]        inst_address;
    logic               is_jump;
    logic               is_branch;
    logic [25:0]        jump_field;
    logic signed [15:0] branch_offset;
    logic [1:0]         new_state;
  } btb_in_t;

  // one output beat
  typedef struct packed {
    logic [31:0] next_pc;
    logic        predicted_taken;
    logic        hit;
  } btb_out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [31:0] lookup_addr;
    logic        fetch_en;
    logic        update_en;
    logic [1:0]  new_state;
    logic [31:0] ins_addr;
    logic [31:0] ins_target;
  } btb_cell_ctrl_t;

  // running minimum handed from cell to cell during a victim scan
  typedef struct packed {
    logic              vld;
    logic [USES_W-1:0] uses;
  } btb_tok_t;

endpackage

`default_nettype wire

// ----- rtl/btb_cell.sv -----
// one buffer entry with its compare and its stage of the victim scan
`default_nettype none

module btb_cell import btb_pkg::*; #(
  parameter int unsigned IdxW    = 4,
  parameter int unsigned CellIdx = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  btb_cell_ctrl_t ctrl_i,
  input  logic           wr_en_i,
  input  btb_tok_t       tok_i,
  input  logic [IdxW-1:0] tok_idx_i,
  output btb_tok_t       tok_o,
  output logic [IdxW-1:0] tok_idx_o,
  output logic           match_o,
  output logic [31:0]    target_o,
  output logic [1:0]     pred_o
);

  logic              valid_q;
  logic [31:0]       addr_q;
  logic [31:0]       target_q;
  logic [1:0]        pred_q, pred_d;
  logic [USES_W-1:0] uses_q, uses_d;
  btb_tok_t          tok_q, tok_d;
  logic [IdxW-1:0]   tok_idx_q, tok_idx_d;

  assign match_o  = valid_q && (addr_q == ctrl_i.lookup_addr);
  assign target_o = target_q;
  assign pred_o   = pred_q;
  assign tok_o     = tok_q;
  assign tok_idx_o = tok_idx_q;

  // entry update: insert, prediction write, saturating use count
  always_comb begin
    pred_d = pred_q;
    uses_d = uses_q;
    if (wr_en_i) begin
      pred_d = PRED_NOT_SET;
      uses_d = USES_W'(1);
    end else if (match_o && ctrl_i.update_en) begin
      pred_d = ctrl_i.new_state;
    end else if (match_o && ctrl_i.fetch_en && (uses_q != USES_MAX)) begin
      uses_d = uses_q + USES_W'(1);
    end
  end

  // scan stage: strictly lower count takes over, so the earlier slot wins a tie
  always_comb begin
    tok_d     = tok_i;
    tok_idx_d = tok_idx_i;
    if (uses_q < tok_i.uses) begin
      tok_d.uses = uses_q;
      tok_idx_d  = IdxW'(CellIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      if (wr_en_i) valid_q <= 1'b1;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      addr_q   <= ctrl_i.ins_addr;
      target_q <= ctrl_i.ins_target;
    end
    pred_q     <= pred_d;
    uses_q     <= uses_d;
    tok_idx_q  <= tok_idx_d;
  end

endmodule

`default_nettype wire

// ----- rtl/branch_target_buffer_unit.sv -----
// top level of the branch target buffer: controller, cell row, result register
`default_nettype none

// Branch target buffer with least-frequently-used replacement, built as a row
// of Entries cells. An accepted beat is held in a register and matched against
// all cells in the lookup state once the output register is free, and its
// result is loaded into the output register then. A fetch that misses and
// must be entered while every slot is filled also finds its victim: a running
// minimum of the use counts travels down the cell row, one cell per cycle.
// The result of that beat is already waiting at the output during the scan.

`include "branch_target_buffer_unit_defines.svh"

module branch_target_buffer_unit import btb_pkg::*; #(
  parameter int unsigned Entries = ENTRIES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  btb_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output btb_out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_SEED = 2'd2;
  localparam logic [1:0] ST_SCAN = 2'd3;

  logic [1:0]      state_q, state_d;
  btb_in_t         req_q;
  logic [CntW-1:0] fill_q, fill_d;
  logic            out_valid_q, out_valid_d;
  btb_out_t        out_q, out_d;

  btb_cell_ctrl_t  ctrl;
  logic [Entries-1:0] match;
  logic [Entries-1:0] wr_en;
  logic [31:0]     cell_target [Entries];
  logic [1:0]      cell_pred   [Entries];
  btb_tok_t        tok     [Entries+1];
  logic [IdxW-1:0] tok_idx [Entries+1];

  logic            hit;
  logic [31:0]     sel_target;
  logic [1:0]      sel_pred;
  logic            act;
  logic            full;
  logic            needs_insert;
  logic            ins_now;
  logic [IdxW-1:0] wr_idx;
  logic [31:0]     seq_pc;
  logic [31:0]     ins_target;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // target arithmetic of the held beat
  assign seq_pc = req_q.inst_address + PC_STEP;
  always_comb begin
    if (req_q.is_jump) begin
      ins_target = {4'b0000, req_q.jump_field, 2'b00};
    end else begin
      ins_target = seq_pc + {{14{req_q.branch_offset[15]}}, req_q.branch_offset, 2'b00};
    end
  end

  // select the one matching entry
  always_comb begin
    sel_target = '0;
    sel_pred   = '0;
    for (int k = 0; k < Entries; k++) begin
      sel_target = sel_target | (cell_target[k] & {32{match[k]}});
      sel_pred   = sel_pred   | (cell_pred[k]   & {2{match[k]}});
    end
  end
  assign hit = |match;

  assign act          = (state_q == ST_LOOK) && (!out_valid_q || !out_stall_i);
  assign full         = (fill_q == CntW'(Entries));
  assign needs_insert = (req_q.op == OP_FETCH) && !hit && (req_q.is_jump || req_q.is_branch);

  // broadcast to the cells
  always_comb begin
    ctrl.lookup_addr = req_q.inst_address;
    ctrl.fetch_en    = act && (req_q.op == OP_FETCH);
    ctrl.update_en   = act && (req_q.op == OP_UPDATE);
    ctrl.new_state   = req_q.new_state;
    ctrl.ins_addr    = req_q.inst_address;
    ctrl.ins_target  = ins_target;
  end

  // slot to write: next free slot, or the victim at the end of the scan
  always_comb begin
    ins_now = 1'b0;
    wr_idx  = fill_q[IdxW-1:0];
    if (act && needs_insert && !full) begin
      ins_now = 1'b1;
    end else if ((state_q == ST_SCAN) && tok[Entries].vld) begin
      ins_now = 1'b1;
      wr_idx  = tok_idx[Entries];
    end
  end

  always_comb begin
    for (int k = 0; k < Entries; k++) begin
      wr_en[k] = ins_now && (wr_idx == IdxW'(k));
    end
  end

  // seed of the victim scan
  assign tok[0]     = '{vld: (state_q == ST_SEED), uses: USES_MAX};
  assign tok_idx[0] = '0;

  // cell row
  for (genvar g = 0; g < Entries; g++) begin : g_cell
    btb_cell #(
      .IdxW    (IdxW),
      .CellIdx (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .wr_en_i   (wr_en[g]),
      .tok_i     (tok[g]),
      .tok_idx_i (tok_idx[g]),
      .tok_o     (tok[g+1]),
      .tok_idx_o (tok_idx[g+1]),
      .match_o   (match[g]),
      .target_o  (cell_target[g]),
      .pred_o    (cell_pred[g])
    );
  end

  // controller
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (act) begin
          if (needs_insert && full) begin
            state_d = ST_SEED;
          end else begin
            state_d = ST_IDLE;
          end
          if (needs_insert && !full) fill_d = fill_q + CntW'(1);
        end
      end
      ST_SEED: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (tok[Entries].vld) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (act) begin
      out_valid_d = 1'b1;
      if (req_q.op == OP_UPDATE) begin
        out_d.next_pc         = '0;
        out_d.predicted_taken = 1'b0;
      end else if (hit && (sel_pred == PRED_TAKEN)) begin
        out_d.next_pc         = sel_target;
        out_d.predicted_taken = 1'b1;
      end else begin
        out_d.next_pc         = seq_pc;
        out_d.predicted_taken = 1'b0;
      end
      out_d.hit = hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) req_q <= in_data_i;
    out_q <= out_d;
  end

  // addresses in the buffer stay unique
  `BTB_ASSERT(a_single_match, $onehot0(match))
  // at most one slot written per cycle
  `BTB_ASSERT(a_single_write, $onehot0(wr_en))
  // fill count never passes the buffer size
  `BTB_ASSERT_NEVER(a_fill_bound, fill_q > CntW'(Entries))
  // a new result only follows a lookup cycle
  `BTB_ASSERT(a_result_from_look, $rose(out_valid_q) |-> $past(state_q == ST_LOOK))
  // the scan ends only while the controller waits for it
  `BTB_ASSERT(a_scan_end, tok[Entries].vld |-> (state_q == ST_SCAN))

endmodule

`default_nettype wire

// ----- tb/branch_target_buffer_unit_test.sv -----
// self-checking testbench for the branch target buffer with lfu replacement
`default_nettype none

module branch_target_buffer_unit_test import btb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES = ENTRIES_DEF;
  localparam logic [1:0] PRED_NOT_TAKEN = 2'd1;
  localparam logic [1:0] PRED_SPARE = 2'd3;
  localparam int unsigned ADDR_POOL = 20;
  localparam int unsigned RANDOM_BEATS = 1000;
  localparam int unsigned HAMMER_BEATS = 64;
  // worst case per beat: victim scan, longest send gap and longest result stall,
  // taken over every planned beat and then several times over
  localparam longint unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned REPORT_CAP = 100;

  typedef struct {
    btb_in_t     beat;
    int unsigned gap;
    bit          hold;
    bit          burst;
  } planned_beat_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  btb_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  btb_out_t out_data_o;

  planned_beat_t beat_plan[$];
  btb_out_t      predicted_q[$];
  int unsigned   fail_count = 0;
  int unsigned   results_seen = 0;
  int unsigned   gap_left = 0;
  bit            burst_now = 1'b0;
  int unsigned   stall_left = 0;
  int unsigned   mon_cycles = 0;
  longint unsigned cycle_count = 0;

  // shadow copy of the buffer contents
  logic        shadow_valid [ENTRIES];
  logic [31:0] shadow_addr  [ENTRIES];
  logic [31:0] shadow_target[ENTRIES];
  logic [1:0]  shadow_pred  [ENTRIES];
  logic [15:0] shadow_uses  [ENTRIES];
  int unsigned shadow_fill = 0;

  branch_target_buffer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(string what);
    if (fail_count < REPORT_CAP) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
    fail_count++;
  endtask

  // lookup, count, insert and replace on the shadow buffer; returns the next pc beat
  function automatic btb_out_t predict_next_pc(btb_in_t b);
    btb_out_t    r;
    int          slot;
    int          victim;
    logic [31:0] tgt;
    r = '0;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && shadow_valid[i] && shadow_addr[i] == b.inst_address) slot = i;
    end
    if (b.op == OP_UPDATE) begin
      if (slot >= 0) begin
        shadow_pred[slot] = b.new_state;
        r.hit = 1'b1;
      end
    end else if (slot >= 0) begin
      r.hit = 1'b1;
      if (shadow_uses[slot] != USES_MAX) shadow_uses[slot] = shadow_uses[slot] + 16'd1;
      if (shadow_pred[slot] == PRED_TAKEN) begin
        r.next_pc = shadow_target[slot];
        r.predicted_taken = 1'b1;
      end else begin
        r.next_pc = b.inst_address + PC_STEP;
      end
    end else begin
      r.next_pc = b.inst_address + PC_STEP;
      if (b.is_jump || b.is_branch) begin
        // jump wins when both flags are set
        if (b.is_jump) tgt = {4'b0, b.jump_field, 2'b00};
        else tgt = b.inst_address + PC_STEP
                   + {{14{b.branch_offset[15]}}, b.branch_offset, 2'b00};
        if (shadow_fill < ENTRIES) begin
          victim = shadow_fill;
          shadow_fill++;
        end else begin
          // lowest use count, first slot on a tie
          victim = 0;
          for (int i = 1; i < ENTRIES; i++) begin
            if (shadow_uses[i] < shadow_uses[victim]) victim = i;
          end
        end
        shadow_valid[victim]  = 1'b1;
        shadow_addr[victim]   = b.inst_address;
        shadow_target[victim] = tgt;
        shadow_pred[victim]   = PRED_NOT_SET;
        shadow_uses[victim]   = 16'd1;
      end
    end
    return r;
  endfunction

  function automatic btb_in_t fetch_beat(logic [31:0] addr, logic jump, logic branch,
                                         logic [25:0] field, logic [15:0] offset);
    btb_in_t b;
    b = '0;
    b.op = OP_FETCH;
    b.inst_address = addr;
    b.is_jump = jump;
    b.is_branch = branch;
    b.jump_field = field;
    b.branch_offset = offset;
    b.new_state = 2'($urandom_range(0, 3));
    return b;
  endfunction

  function automatic btb_in_t update_beat(logic [31:0] addr, logic [1:0] state);
    btb_in_t b;
    b = '0;
    b.op = OP_UPDATE;
    b.inst_address = addr;
    b.is_jump = 1'($urandom_range(0, 1));
    b.is_branch = 1'($urandom_range(0, 1));
    b.jump_field = 26'($urandom);
    b.branch_offset = 16'($urandom);
    b.new_state = state;
    return b;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [31:0] fresh_addr();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 3) != 0) a[1:0] = 2'b00;
    return a;
  endfunction

  task automatic plan(btb_in_t b, int unsigned gap, bit hold, bit burst);
    planned_beat_t p;
    p.beat = b;
    p.gap = gap;
    p.hold = hold;
    p.burst = burst;
    beat_plan.push_back(p);
  endtask

  // input driver: predicts on each accepted beat, then presents the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      gap_left <= 0;
      burst_now <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predicted_q.push_back(predict_next_pc(in_data_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (beat_plan.size() != 0 &&
                     !(beat_plan[0].hold && predicted_q.size() != 0)) begin
          in_valid_i <= 1'b1;
          in_data_i <= beat_plan[0].beat;
          burst_now <= beat_plan[0].burst;
          gap_left <= (beat_plan.size() > 1) ? beat_plan[1].gap : 0;
          void'(beat_plan.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    btb_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      mon_cycles++;
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (predicted_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding, next_pc %h",
                                    out_data_o.next_pc));
        end else begin
          want = predicted_q.pop_front();
          if (out_data_o.next_pc !== want.next_pc)
            report_mismatch($sformatf("next_pc %h, predicted %h",
                                      out_data_o.next_pc, want.next_pc));
          if (out_data_o.predicted_taken !== want.predicted_taken)
            report_mismatch($sformatf("predicted_taken %b, predicted %b",
                                      out_data_o.predicted_taken, want.predicted_taken));
          if (out_data_o.hit !== want.hit)
            report_mismatch($sformatf("hit %b, predicted %b", out_data_o.hit, want.hit));
        end
      end
      // quiet windows and burst phases start no new stalls
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (burst_now || mon_cycles[8:7] == 2'b00) begin
        out_stall_i <= 1'b0;
      end else begin
        stall_left <= idle_gap();
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("branch_target_buffer_unit_test NOT OK");
      $finish;
    end
  end

  // stimulus plan, reset and end of run
  initial begin
    logic [31:0] pool[ADDR_POOL];
    btb_in_t     b;
    int unsigned r;
    int unsigned total_beats;
    bit          calm;
    logic [31:0] sat_addr;

    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_addr[i] = '0;
      shadow_target[i] = '0;
      shadow_pred[i] = PRED_NOT_SET;
      shadow_uses[i] = '0;
    end

    // directed: plain miss, wrap of the next pc, field extremes, jump over branch
    sat_addr = 32'hFFFF_FFFC;
    plan(fetch_beat(32'h0, 1'b0, 1'b0, '0, '0), 0, 0, 0);
    plan(fetch_beat(sat_addr, 1'b1, 1'b0, '1, '0), 0, 0, 0);
    plan(update_beat(sat_addr, PRED_TAKEN), 0, 0, 0);
    plan(fetch_beat(sat_addr, 1'b0, 1'b0, '0, '0), 0, 0, 0);
    plan(fetch_beat(32'h0000_1000, 1'b0, 1'b1, '0, 16'h8000), 1, 0, 0);
    plan(fetch_beat(32'h0000_2000, 1'b0, 1'b1, '1, 16'h7FFF), 0, 0, 0);
    plan(fetch_beat(32'h0000_3000, 1'b1, 1'b1, '0, 16'hFFFF), 2, 0, 0);
    plan(update_beat(32'h0000_1000, PRED_TAKEN), 0, 0, 0);
    plan(fetch_beat(32'h0000_1000, 1'b1, 1'b1, '1, '1), 0, 0, 0);
    plan(update_beat(32'h0000_2000, PRED_TAKEN), 0, 0, 0);
    plan(fetch_beat(32'h0000_2000, 1'b0, 1'b0, '0, '0), 0, 0, 0);
    // state three predicts like not taken
    plan(update_beat(32'h0000_2000, PRED_SPARE), 0, 0, 0);
    plan(fetch_beat(32'h0000_2000, 1'b0, 1'b0, '0, '0), 0, 0, 0);
    // update of an address that is not held writes nothing
    plan(update_beat(32'hDEAD_BEE0, PRED_TAKEN), 0, 0, 0);
    plan(fetch_beat(32'hDEAD_BEE0, 1'b0, 1'b0, '0, '0), 0, 0, 0);
    plan(update_beat(32'h0000_3000, PRED_TAKEN), 0, 0, 0);
    plan(fetch_beat(32'h0000_3000, 1'b0, 1'b0, '0, '0), 3, 0, 0);
    plan(update_beat(32'h0000_3000, PRED_NOT_TAKEN), 0, 0, 0);
    plan(fetch_beat(32'h0000_3000, 1'b0, 1'b0, '0, '0), 0, 0, 0);
    plan(update_beat(32'h0000_3000, PRED_NOT_SET), 0, 0, 0);
    plan(fetch_beat(32'hFFFF_FFFF, 1'b0, 1'b0, '1, '1), 0, 0, 0);

    // back-to-back hits on one entry in a burst phase that starts no output stalls
    for (int n = 0; n < HAMMER_BEATS; n++)
      plan(fetch_beat(sat_addr, 1'b0, 1'b0, 26'($urandom), 16'($urandom)), 0, n == 0, 1);

    // random: mostly inserts, updates and lookups over a small address pool
    for (int i = 0; i < ADDR_POOL; i++) pool[i] = fresh_addr();
    calm = 1'b0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 19) == 0) pool[$urandom_range(0, ADDR_POOL - 1)] = fresh_addr();
      r = $urandom_range(0, 99);
      if (r < 35) begin
        b = fetch_beat(pool[$urandom_range(0, ADDR_POOL - 1)], 1'b0, 1'b0,
                       26'($urandom), 16'($urandom));
        case ($urandom_range(0, 2))
          0: b.is_jump = 1'b1;
          1: b.is_branch = 1'b1;
          default: begin
            b.is_jump = 1'b1;
            b.is_branch = 1'b1;
          end
        endcase
      end else if (r < 60) begin
        b = fetch_beat(pool[$urandom_range(0, ADDR_POOL - 1)], 1'b0, 1'b0,
                       26'($urandom), 16'($urandom));
      end else if (r < 88) begin
        b = update_beat(pool[$urandom_range(0, ADDR_POOL - 1)],
                        ($urandom_range(0, 1) != 0) ? PRED_TAKEN : 2'($urandom_range(0, 3)));
      end else begin
        // noise over the whole field ranges
        b = fetch_beat($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       26'($urandom), 16'($urandom));
        b.op = $urandom_range(0, 1) ? OP_UPDATE : OP_FETCH;
      end
      plan(b, calm ? 0 : idle_gap(), n == RANDOM_BEATS / 2, 0);
    end
    total_beats = beat_plan.size();

    // reset
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (results_seen < total_beats) @(posedge clk_i);
    // room for a victim scan and any stray beat
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (predicted_q.size() != 0)
      report_mismatch($sformatf("%0d predicted beats never came", predicted_q.size()));

    if (fail_count == 0) begin
      $display("branch_target_buffer_unit_test OK");
    end else begin
      $display("branch_target_buffer_unit_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
